// ----- sv/rlwc_pkg.sv -----
// ----------------------------------------------------------------------------
// rlwc_pkg
// Shared types and constants for the radial lens warp address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rlwc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam int unsigned SRC_W  = 24;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned OUT_W  = 2 * SRC_W + GAIN_W;

  localparam logic [15:0] RESCALE_RST = 16'h4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X       = 3'd0,
    REG_CENTRE_Y       = 3'd1,
    REG_NORM_RADIUS_SQ = 3'd2,
    REG_MAIN_COEF      = 3'd3,
    REG_EDGE_COEF      = 3'd4,
    REG_RESCALE_FACTOR = 3'd5,
    REG_BRIGHTEN_COEF  = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- sv/radial_lens_warp_coordinates.sv -----
// ----------------------------------------------------------------------------
// radial_lens_warp_coordinates
// Maps a destination pixel to its source coordinate and brightness gain
// under a radial lens distortion model, in fixed point with saturation.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock unless a stalled output has filled
// the pipeline, and returns the results in order, one result per input. The
// datapath has twelve register stages: squares, a split product of the
// squared radius, the polynomial terms, the zoom factor and a split product
// for the final coordinates. Stages with no valid data are filled while the
// output stalls, and s_axis_tready follows m_axis_tready combinationally.
// Registers must be written only while no transaction is in flight; this
// binds the user, and the block itself does not enforce it.
`default_nettype none

module radial_lens_warp_coordinates #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rlwc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [rlwc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // Fields from bit 0: dest_x, dest_y, zero padding.
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // Fields from bit 0: source_x, source_y, gain.
  output logic [rlwc_pkg::OUT_W-1:0]               m_axis_tdata
);

  localparam int unsigned NSTG  = 12;
  localparam int unsigned DX_W  = COORD_BITS + 4;
  localparam int unsigned OFF_W = ((DX_W > 16) ? DX_W : 16) + 1;
  localparam int unsigned SQ1_W = 2 * OFF_W - 1;
  localparam int unsigned SQ_W  = 2 * OFF_W;
  localparam int unsigned SQL_W = (SQ_W + 1) / 2;
  localparam int unsigned SQH_W = SQ_W - SQL_W;
  localparam int unsigned PP_W  = SQL_W + 20;
  localparam int unsigned P_W   = SQ_W + 40;
  localparam int unsigned PL_W  = OFF_W + 23;
  localparam int unsigned PH_W  = OFF_W + 22;
  localparam int unsigned PR_W  = OFF_W + 45;
  localparam int unsigned SW    = PR_W - 25;
  localparam int unsigned SRC_W = rlwc_pkg::SRC_W;
  localparam int unsigned G_W   = rlwc_pkg::GAIN_W;

  localparam logic signed [35:0]     M_HI  = 36'sd16777216;
  localparam logic signed [35:0]     M_LO  = -36'sd16777216;
  localparam logic signed [PR_W-1:0] RND26 = PR_W'(33554432);

  // Configuration registers.
  logic        [15:0] centre_x_q, centre_y_q, rescale_q;
  logic        [39:0] norm_q;
  logic signed [15:0] main_q, edge_q, bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      norm_q     <= '0;
      main_q     <= '0;
      edge_q     <= '0;
      rescale_q  <= rlwc_pkg::RESCALE_RST;
      bright_q   <= '0;
    end else if (cfg_we_i) begin
      case (rlwc_pkg::cfg_reg_e'(cfg_idx_i))
        rlwc_pkg::REG_CENTRE_X:       centre_x_q <= cfg_data_i[15:0];
        rlwc_pkg::REG_CENTRE_Y:       centre_y_q <= cfg_data_i[15:0];
        rlwc_pkg::REG_NORM_RADIUS_SQ: norm_q     <= cfg_data_i[39:0];
        rlwc_pkg::REG_MAIN_COEF:      main_q     <= $signed(cfg_data_i[15:0]);
        rlwc_pkg::REG_EDGE_COEF:      edge_q     <= $signed(cfg_data_i[15:0]);
        rlwc_pkg::REG_RESCALE_FACTOR: rescale_q  <= cfg_data_i[15:0];
        rlwc_pkg::REG_BRIGHTEN_COEF:  bright_q   <= $signed(cfg_data_i[15:0]);
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control.
  logic [NSTG-1:0] vld_q, vld_d, adv;

  for (genvar k = 0; k < NSTG; k++) begin : g_adv
    assign adv[k] = m_axis_tready | ~(&vld_q[NSTG-1:k]);
  end

  always_comb begin
    vld_d[0] = adv[0] ? s_axis_tvalid : vld_q[0];
    for (int unsigned k = 1; k < NSTG; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  // Stage 0: offsets from the centre.
  logic [COORD_BITS-1:0]   dest_x, dest_y;
  logic signed [OFF_W-1:0] off_x_d, off_y_d;
  logic signed [OFF_W-1:0] off_x_q [0:8];
  logic signed [OFF_W-1:0] off_y_q [0:8];

  assign dest_x  = s_axis_tdata[COORD_BITS-1:0];
  assign dest_y  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign off_x_d = OFF_W'({dest_x, 4'b0000}) - OFF_W'(centre_x_q);
  assign off_y_d = OFF_W'({dest_y, 4'b0000}) - OFF_W'(centre_y_q);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      off_x_q[0] <= off_x_d;
      off_y_q[0] <= off_y_d;
    end
    for (int unsigned k = 1; k < 9; k++) begin
      if (adv[k]) begin
        off_x_q[k] <= off_x_q[k-1];
        off_y_q[k] <= off_y_q[k-1];
      end
    end
  end

  // Stage 1: squares.
  logic signed [SQ_W-1:0] sqx_full, sqy_full;
  logic [SQ1_W-1:0]       sqx_q, sqy_q;

  assign sqx_full = off_x_q[0] * off_x_q[0];
  assign sqy_full = off_y_q[0] * off_y_q[0];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sqx_q <= sqx_full[SQ1_W-1:0];
      sqy_q <= sqy_full[SQ1_W-1:0];
    end
  end

  // Stage 2: sum of squares.
  logic [SQ_W-1:0] sq_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sq_q <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
    end
  end

  // Stage 3: partial products of the squared radius and the normalizer.
  logic [SQL_W-1:0] sq_l;
  logic [SQH_W-1:0] sq_h;
  logic [19:0]      nrm_l, nrm_h;
  logic [PP_W-1:0]  pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;

  assign sq_l  = sq_q[SQL_W-1:0];
  assign sq_h  = sq_q[SQ_W-1:SQL_W];
  assign nrm_l = norm_q[19:0];
  assign nrm_h = norm_q[39:20];

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      pp_ll_q <= PP_W'(sq_l) * PP_W'(nrm_l);
      pp_lh_q <= PP_W'(sq_l) * PP_W'(nrm_h);
      pp_hl_q <= PP_W'(sq_h) * PP_W'(nrm_l);
      pp_hh_q <= PP_W'(sq_h) * PP_W'(nrm_h);
    end
  end

  // Stage 4: normalized squared radius, saturated.
  logic [P_W-1:0] prod_r2;
  logic [23:0]    r2_d, r2_q;

  assign prod_r2 = (P_W'(pp_hh_q) << (SQL_W + 20)) + (P_W'(pp_hl_q) << SQL_W)
                 + (P_W'(pp_lh_q) << 20) + P_W'(pp_ll_q);
  assign r2_d    = (|prod_r2[P_W-1:54]) ? 24'hFFFFFF : prod_r2[53:30];

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      r2_q <= r2_d;
    end
  end

  // Stage 5: radius to the fourth and the quadratic term.
  logic [47:0]        r2sq_full;
  logic [31:0]        r2sq_q;
  logic signed [40:0] r2main_d, r2main5_q, r2main6_q;

  assign r2sq_full = 48'(r2_q) * 48'(r2_q);
  assign r2main_d  = $signed({1'b0, r2_q}) * main_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      r2sq_q    <= r2sq_full[47:16];
      r2main5_q <= r2main_d;
    end
  end

  // Stage 6: quartic term.
  logic signed [48:0] r2sqe_d, r2sqe_q;

  assign r2sqe_d = $signed({1'b0, r2sq_q}) * edge_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      r2sqe_q   <= r2sqe_d;
      r2main6_q <= r2main5_q;
    end
  end

  // Stage 7: distortion term, clamped.
  logic signed [49:0] m30;
  logic signed [35:0] m_fl;
  logic signed [25:0] m_d, m_q;

  assign m30  = 50'(r2main6_q) + 50'(r2sqe_q);
  assign m_fl = $signed(m30[49:14]);

  always_comb begin
    if (m_fl > M_HI) begin
      m_d = 26'sd16777216;
    end else if (m_fl < M_LO) begin
      m_d = -26'sd16777216;
    end else begin
      m_d = 26'(m_fl);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      m_q <= m_d;
    end
  end

  // Stage 8: zoom multiplier and gain product.
  logic signed [26:0] opm;
  logic signed [43:0] mult_d, mult_q;
  logic signed [41:0] gprod_d, gprod_q;

  assign opm     = 27'(m_q) + 27'sd65536;
  assign mult_d  = $signed({1'b0, rescale_q}) * opm;
  assign gprod_d = m_q * bright_q;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      mult_q  <= mult_d;
      gprod_q <= gprod_d;
    end
  end

  // Stage 9: split products with the offsets, and the gain.
  logic signed [PL_W-1:0] px_lo_q, py_lo_q;
  logic signed [PH_W-1:0] px_hi_q, py_hi_q;
  logic signed [22:0]     mult_lo;
  logic signed [21:0]     mult_hi;
  logic signed [42:0]     gsum;
  logic signed [27:0]     gfull;
  logic signed [G_W-1:0]  gain_d, gain9_q, gain10_q;

  assign mult_lo = $signed({1'b0, mult_q[21:0]});
  assign mult_hi = $signed(mult_q[43:22]);
  assign gsum    = 43'(gprod_q) + 43'sd32768;
  assign gfull   = 28'($signed(gsum[42:16])) + 28'sd2048;

  always_comb begin
    if ((&gfull[27:G_W-1]) || !(|gfull[27:G_W-1])) begin
      gain_d = G_W'(gfull);
    end else if (gfull[27]) begin
      gain_d = 16'sh8000;
    end else begin
      gain_d = 16'sh7FFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      px_lo_q <= mult_lo * off_x_q[8];
      px_hi_q <= mult_hi * off_x_q[8];
      py_lo_q <= mult_lo * off_y_q[8];
      py_hi_q <= mult_hi * off_y_q[8];
      gain9_q <= gain_d;
    end
  end

  // Stage 10: recombine and add the rounding constant.
  logic signed [PR_W-1:0] prodx_q, prody_q;

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      prodx_q  <= (PR_W'(px_hi_q) <<< 22) + PR_W'(px_lo_q) + RND26;
      prody_q  <= (PR_W'(py_hi_q) <<< 22) + PR_W'(py_lo_q) + RND26;
      gain10_q <= gain9_q;
    end
  end

  // Stage 11: add the centre and saturate.
  logic signed [SW-1:0]    srcx_sum, srcy_sum;
  logic signed [SRC_W-1:0] srcx_d, srcy_d, srcx_q, srcy_q;
  logic signed [G_W-1:0]   gain_q;

  assign srcx_sum = SW'($signed(prodx_q[PR_W-1:26]))
                  + SW'($signed({1'b0, centre_x_q, 4'b0000}));
  assign srcy_sum = SW'($signed(prody_q[PR_W-1:26]))
                  + SW'($signed({1'b0, centre_y_q, 4'b0000}));

  always_comb begin
    if ((&srcx_sum[SW-1:SRC_W-1]) || !(|srcx_sum[SW-1:SRC_W-1])) begin
      srcx_d = SRC_W'(srcx_sum);
    end else if (srcx_sum[SW-1]) begin
      srcx_d = 24'sh800000;
    end else begin
      srcx_d = 24'sh7FFFFF;
    end
    if ((&srcy_sum[SW-1:SRC_W-1]) || !(|srcy_sum[SW-1:SRC_W-1])) begin
      srcy_d = SRC_W'(srcy_sum);
    end else if (srcy_sum[SW-1]) begin
      srcy_d = 24'sh800000;
    end else begin
      srcy_d = 24'sh7FFFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      srcx_q <= srcx_d;
      srcy_q <= srcy_d;
      gain_q <= gain10_q;
    end
  end

  assign m_axis_tdata = {gain_q, srcy_q, srcx_q};

endmodule

`default_nettype wire

// ----- sv/rlwc_checker.sv -----
// ----------------------------------------------------------------------------
// rlwc_checker
// Port-level checks on flow control of the radial lens warp address generator.
// ----------------------------------------------------------------------------
`default_nettype none

module rlwc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [rlwc_pkg::OUT_W-1:0]   m_axis_tdata
);

  // A downstream that takes results never stalls the input.
  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

  // With no result waiting the pipeline has room.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_valid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before transaction");

  a_data_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind radial_lens_warp_coordinates rlwc_checker u_rlwc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
